/* design/cdq_pkg.sv */
package cdq_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 8;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

/* design/cdq_ctrl.sv */
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output cdq_pkg::cmd_t cmd
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      cdq_pkg::ST_IDLE: begin
        state_next = start ? cdq_pkg::ST_EXEC : cdq_pkg::ST_IDLE;
      end
      cdq_pkg::ST_EXEC: begin
        state_next = cdq_pkg::ST_RESP;
      end
      cdq_pkg::ST_RESP: begin
        state_next = cdq_pkg::ST_IDLE;
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = (state != cdq_pkg::ST_IDLE);
    done     = (state == cdq_pkg::ST_RESP);
    cmd.load = (state == cdq_pkg::ST_IDLE) && start;
    cmd.exec = (state == cdq_pkg::ST_EXEC);
  end

endmodule

/* design/cdq_datapath.sv */
module cdq_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  cdq_pkg::cmd_t                    cmd,
  input  logic [1:0]                       kind,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
  input  logic                             cfg_write,
  input  logic [cdq_pkg::CFG_W-1:0]        cfg_data,
  output logic [1:0]                       status,
  output logic signed [cdq_pkg::DATA_W-1:0] removed_value
);

  logic [cdq_pkg::DATA_W-1:0] slot_store [cdq_pkg::DEPTH];

  cdq_pkg::kind_t             kind_q;
  logic [cdq_pkg::DATA_W-1:0] value_q;
  logic [cdq_pkg::CAP_W-1:0]  cap_eff;
  logic [cdq_pkg::IDX_W-1:0]  head_index;
  logic [cdq_pkg::IDX_W-1:0]  tail_index;
  logic                       is_empty;
  cdq_pkg::status_t           status_q;
  logic                       pop_ok;
  logic [cdq_pkg::DATA_W-1:0] rdata;

  logic [cdq_pkg::IDX_W-1:0]  head_index_next;
  logic [cdq_pkg::IDX_W-1:0]  tail_index_next;
  logic                       is_empty_next;
  cdq_pkg::status_t           status_next;
  logic                       pop_ok_next;
  logic [cdq_pkg::IDX_W-1:0]  last_idx;
  logic [cdq_pkg::IDX_W-1:0]  head_inc;
  logic [cdq_pkg::IDX_W-1:0]  head_dec;
  logic [cdq_pkg::IDX_W-1:0]  tail_inc;
  logic [cdq_pkg::IDX_W-1:0]  tail_dec;
  logic                       is_push;
  logic                       is_front;
  logic                       full;
  logic                       we;
  logic [cdq_pkg::IDX_W-1:0]  waddr;
  logic [cdq_pkg::IDX_W-1:0]  raddr;
  logic [cdq_pkg::CAP_W-1:0]  cap_wr;
  logic [cdq_pkg::CAP_W-1:0]  cfg_ext;

  always_comb begin
    cfg_ext = cdq_pkg::CAP_W'(cfg_data);
    if (cfg_data == '0) begin
      cap_wr = cdq_pkg::CAP_W'(1);
    end else if (cfg_ext > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
      cap_wr = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
    end else begin
      cap_wr = cfg_ext;
    end
  end

  always_comb begin
    last_idx = cdq_pkg::IDX_W'(cap_eff - cdq_pkg::CAP_W'(1));
    head_inc = (head_index == last_idx) ? '0 : head_index + cdq_pkg::IDX_W'(1);
    head_dec = (head_index == '0) ? last_idx : head_index - cdq_pkg::IDX_W'(1);
    tail_inc = (tail_index == last_idx) ? '0 : tail_index + cdq_pkg::IDX_W'(1);
    tail_dec = (tail_index == '0) ? last_idx : tail_index - cdq_pkg::IDX_W'(1);
    is_push  = (kind_q == cdq_pkg::KIND_PUSH_FRONT) || (kind_q == cdq_pkg::KIND_PUSH_BACK);
    is_front = (kind_q == cdq_pkg::KIND_PUSH_FRONT) || (kind_q == cdq_pkg::KIND_POP_FRONT);
    full     = !is_empty && (tail_inc == head_index);
    raddr    = is_front ? head_index : tail_index;
  end

  always_comb begin
    head_index_next = head_index;
    tail_index_next = tail_index;
    is_empty_next   = is_empty;
    status_next     = cdq_pkg::STAT_DONE;
    pop_ok_next     = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    if (is_push) begin
      if (full) begin
        status_next = cdq_pkg::STAT_OVERFLOW;
      end else if (is_empty) begin
        head_index_next = '0;
        tail_index_next = '0;
        is_empty_next   = 1'b0;
        we              = 1'b1;
      end else if (is_front) begin
        head_index_next = head_dec;
        we              = 1'b1;
        waddr           = head_dec;
      end else begin
        tail_index_next = tail_inc;
        we              = 1'b1;
        waddr           = tail_inc;
      end
    end else begin
      if (is_empty) begin
        status_next = cdq_pkg::STAT_UNDERFLOW;
      end else begin
        pop_ok_next = 1'b1;
        if (head_index == tail_index) begin
          head_index_next = '0;
          tail_index_next = '0;
          is_empty_next   = 1'b1;
        end else if (is_front) begin
          head_index_next = head_inc;
        end else begin
          tail_index_next = tail_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= cdq_pkg::kind_t'(kind);
      value_q <= push_value;
    end
    if (cmd.exec) begin
      status_q <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff    <= cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
      head_index <= '0;
      tail_index <= '0;
      is_empty   <= 1'b1;
      pop_ok     <= 1'b0;
    end else if (cfg_write) begin
      cap_eff    <= cap_wr;
      head_index <= '0;
      tail_index <= '0;
      is_empty   <= 1'b1;
    end else if (cmd.exec) begin
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      is_empty   <= is_empty_next;
      pop_ok     <= pop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      slot_store[waddr] <= value_q;
    end
    rdata <= slot_store[raddr];
  end

  assign status        = status_q;
  assign removed_value = pop_ok ? rdata : '0;

  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head_index == '0) && (tail_index == '0))
    else $error("Empty queue with nonzero index.");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (cdq_pkg::CAP_W'(head_index) < cap_eff) && (cdq_pkg::CAP_W'(tail_index) < cap_eff))
    else $error("Index at or beyond capacity.");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !cfg_write && is_empty && !is_push |=>
      (status_q == cdq_pkg::STAT_UNDERFLOW) && !pop_ok)
    else $error("Pop on empty queue not reported as underflow.");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !cfg_write && is_push && !full |=> !is_empty)
    else $error("Queue empty after a successful push.");

endmodule

/* design/circular_deque_top.sv */
// An item is accepted at a clock edge while the controller is idle; its result comes with done
// high in the RESP state, after the EXEC state. No new item is taken while busy, until the last
// result has been shown; the store write or read and the result register both happen in EXEC.
// Reset (rst, synchronous) empties the queue and sets capacity to 128; store contents are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circular_deque_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
  input  logic                             cfg_write,
  input  logic [cdq_pkg::CFG_W-1:0]        cfg_data,
  output logic                             done,
  output logic [1:0]                       status,
  output logic signed [cdq_pkg::DATA_W-1:0] removed_value
);

  cdq_pkg::cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cdq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (kind),
    .push_value    (push_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .status        (status),
    .removed_value (removed_value)
  );

endmodule

/* tb/deque_checker.sv */
`timescale 1ns / 100ps

module deque_checker
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     cfg_write,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     done,
  input  logic [1:0]               status,
  input  logic signed [DATA_W-1:0] removed_value,
  output int                       errors,
  output int                       pending,
  output int                       results_seen,
  output int                       overflows,
  output int                       underflows
);

  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] val;
  } outcome_t;

  outcome_t          awaited_outcomes[$];
  logic [CFG_W-1:0]  cap_setting;
  int                front_slot;
  int                back_slot;
  logic              queue_empty;
  logic [DATA_W-1:0] slots [DEPTH];

  function automatic int used_capacity();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH) return DEPTH;
    return int'(cap_setting);
  endfunction

  function automatic int wrap_next(int i, int c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int wrap_prev(int i, int c);
    return (i == 0) ? c - 1 : i - 1;
  endfunction

  task automatic clear_deque();
    front_slot  = 0;
    back_slot   = 0;
    queue_empty = 1'b1;
  endtask

  task automatic deque_step(input kind_t k, input logic [DATA_W-1:0] v, output outcome_t r);
    int c;
    c = used_capacity();
    r.st = STAT_DONE;
    r.val = '0;
    if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
      if (!queue_empty && wrap_next(back_slot, c) == front_slot) begin
        r.st = STAT_OVERFLOW;
      end else if (queue_empty) begin
        front_slot  = 0;
        back_slot   = 0;
        queue_empty = 1'b0;
        slots[0]    = v;
      end else if (k == KIND_PUSH_FRONT) begin
        front_slot = wrap_prev(front_slot, c);
        slots[front_slot] = v;
      end else begin
        back_slot = wrap_next(back_slot, c);
        slots[back_slot] = v;
      end
    end else if (queue_empty) begin
      r.st = STAT_UNDERFLOW;
    end else begin
      r.val = slots[(k == KIND_POP_FRONT) ? front_slot : back_slot];
      if (front_slot == back_slot) begin
        clear_deque();
      end else if (k == KIND_POP_FRONT) begin
        front_slot = wrap_next(front_slot, c);
      end else begin
        back_slot = wrap_prev(back_slot, c);
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      cap_setting = 8'd128;
      clear_deque();
      awaited_outcomes.delete();
      errors       <= 0;
      results_seen <= 0;
      overflows    <= 0;
      underflows   <= 0;
    end else begin
      if (done) begin
        results_seen <= results_seen + 1;
        if (status == STAT_OVERFLOW) overflows <= overflows + 1;
        if (status == STAT_UNDERFLOW) underflows <= underflows + 1;
        if (awaited_outcomes.size() == 0) begin
          if (errors < 10)
            $display("[%0t] unexpected result: status %0d removed_value %0d",
                     $realtime, status, removed_value);
          errors <= errors + 1;
        end else begin
          want = awaited_outcomes.pop_front();
          if (status !== want.st || removed_value !== want.val) begin
            if (errors < 10)
              $display("[%0t] mismatch: status exp %0d got %0d, removed_value exp %0d got %0d",
                       $realtime, want.st, status, want.val, removed_value);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_write) begin
        cap_setting = cfg_data;
        clear_deque();
      end
      if (start && !busy) begin
        deque_step(kind_t'(kind), push_value, got);
        awaited_outcomes.push_back(got);
      end
    end
    pending <= awaited_outcomes.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  kind_t                    kind;
  logic signed [DATA_W-1:0] push_value;
  logic                     cfg_write;
  logic [CFG_W-1:0]         cfg_data;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] removed_value;

  int errors;
  int pending;
  int results_seen;
  int overflows;
  int underflows;
  int items_sent;
  int settings_used;
  int stall_cycles;
  bit no_gaps;

  circular_deque_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .push_value    (push_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .removed_value (removed_value)
  );

  deque_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .push_value    (push_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .errors        (errors),
    .pending       (pending),
    .results_seen  (results_seen),
    .overflows     (overflows),
    .underflows    (underflows)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_item(input kind_t k, input logic [DATA_W-1:0] v);
    int r;
    int gap;
    start      <= 1'b1;
    kind       <= k;
    push_value <= v;
    do @(posedge clk); while (busy);
    items_sent++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] cap, input int n_items);
    int used;
    int seg_left;
    bit filling;
    int bias;
    kind_t k;
    used = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : int'(cap));
    set_capacity(cap);
    no_gaps = ($urandom_range(0, 3) == 0);
    filling = 1'b1;
    seg_left = 2 * used + $urandom_range(0, 3);
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        filling = !filling;
        seg_left = 2 * used + $urandom_range(0, 3);
      end
      seg_left--;
      bias = filling ? 90 : 10;
      if ($urandom_range(0, 9) == 0) bias = 50;
      if ($urandom_range(0, 99) < bias)
        k = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else
        k = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      run_item(k, pick_value());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    kind       <= KIND_PUSH_FRONT;
    push_value <= '0;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    items_sent    = 0;
    settings_used = 0;
    no_gaps       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_item(KIND_POP_FRONT, 32'h1234_5678);
    run_item(KIND_POP_BACK, 32'hffff_ffff);
    run_item(KIND_PUSH_BACK, 32'h7fff_ffff);
    run_item(KIND_PUSH_FRONT, 32'h8000_0000);
    run_item(KIND_PUSH_BACK, 32'h0000_0000);
    run_item(KIND_PUSH_FRONT, 32'hffff_ffff);
    run_item(KIND_POP_FRONT, 32'h0);
    run_item(KIND_POP_BACK, 32'h0);
    run_item(KIND_POP_BACK, 32'h0);
    run_item(KIND_POP_FRONT, 32'h0);
    run_item(KIND_POP_BACK, 32'h0);

    set_capacity(8'd1);
    run_item(KIND_PUSH_FRONT, 32'h5555_aaaa);
    run_item(KIND_PUSH_BACK, 32'haaaa_5555);
    run_item(KIND_PUSH_FRONT, 32'h0000_0001);
    run_item(KIND_POP_BACK, 32'h0);
    run_item(KIND_POP_FRONT, 32'h0);

    set_capacity(8'd0);
    run_item(KIND_PUSH_BACK, 32'h0f0f_0f0f);
    run_item(KIND_PUSH_FRONT, 32'hf0f0_f0f0);
    run_item(KIND_POP_FRONT, 32'h0);

    set_capacity(8'd2);
    run_item(KIND_PUSH_BACK, 32'h0000_0002);
    run_item(KIND_PUSH_FRONT, 32'hffff_fffe);
    run_item(KIND_PUSH_BACK, 32'h0000_0003);
    run_item(KIND_POP_BACK, 32'h0);
    run_item(KIND_POP_BACK, 32'h0);

    random_phase(8'd1, 40);
    random_phase(8'd0, 40);
    random_phase(8'd2, 40);
    random_phase(8'd3, 40);
    random_phase(8'd7, 40);
    random_phase(8'($urandom_range(4, 127)), 40);
    random_phase(8'd128, 300);
    random_phase(8'($urandom_range(129, 255)), 20);
    random_phase(8'd255, 20);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d items across %0d capacity settings, including zero and above depth.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d overflows and %0d underflows.",
             results_seen, overflows, underflows);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
design/cdq_pkg.sv
design/cdq_ctrl.sv
design/cdq_datapath.sv
design/circular_deque_top.sv
tb/deque_checker.sv
tb/tb_top.sv
